// ===== design/dnd_pkg.sv =====
// shared types and constants of the dns name decompressor
// used by the controller, the datapath, the top level and the checker
package dnd_pkg;

   localparam int PACKET_BYTES_DEF = 512;
   localparam int MAX_JUMPS_DEF    = 16;

   // store positions: wide enough for any store depth and any pointer target
   localparam int POS_W = 17;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   localparam logic [7:0] PTR_MARK   = 8'd192;
   localparam logic [7:0] LABEL_MAX  = 8'd63;
   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [9:0] NAME_LIMIT = 10'd255;

   typedef struct packed {
      logic       kind;
      logic [8:0] address;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] char_a;
      logic [7:0] char_b;
      logic [7:0] char_c;
      logic [7:0] char_d;
      logic [2:0] char_count;
      logic       last;
      logic [8:0] consumed;
      logic       error;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_WRITE,
      OP_INIT,
      OP_READ_POS,
      OP_TERM,
      OP_PTR_HI,
      OP_JUMP,
      OP_LABEL,
      OP_CHAR,
      OP_OUT_START,
      OP_EMIT,
      OP_FAIL
   } dp_op_type;

   typedef struct packed {
      logic pos_outside;
      logic byte_zero;
      logic byte_ptr;
      logic byte_reserved;
      logic term_overlong;
      logic label_overlong;
      logic label_outside;
      logic ptr2_outside;
      logic jumps_spent;
      logic target_outside;
      logic label_end;
      logic group_last;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_PTR_LO,
      ST_LABEL,
      ST_OUT_RD,
      ST_EMIT,
      ST_FAIL
   } state_type;

endpackage

// ===== design/dnd_datapath.sv =====
// datapath of the dns name decompressor: packet store, text buffer,
// walk registers and result register; depends on dnd_pkg
module dnd_datapath
   import dnd_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   parameter int MAX_JUMPS    = MAX_JUMPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_op_type     op,
   input  req_type       req,
   output dp_status_type status,
   output logic          rsp_strobe,
   output rsp_type       rsp
);

   localparam int AW = $clog2(PACKET_BYTES);
   localparam int JW = $clog2(MAX_JUMPS + 1);
   localparam logic [POS_W-1:0] PKT_LIM  = POS_W'(PACKET_BYTES);
   localparam logic [JW-1:0]    JUMP_LIM = JW'(MAX_JUMPS);

   logic [7:0]       store [PACKET_BYTES];
   logic [3:0][7:0]  txt_mem [64];

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [5:0]       rem_ff, rem_in;
   logic [JW-1:0]    jumps_ff, jumps_in;
   logic             jumped_ff, jumped_in;
   logic [8:0]       consumed_ff, consumed_in;
   logic [8:0]       name_len_ff, name_len_in;
   logic [7:0]       text_len_ff, text_len_in;
   logic [5:0]       grp_ff, grp_in;
   logic [5:0]       hi_ff, hi_in;
   logic [7:0]       st_rd_ff;
   logic [3:0][7:0]  txt_rd_ff;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             st_we, st_re;
   logic [POS_W-1:0] wr_ext, st_raddr;
   logic             txt_we, txt_re;
   logic [7:0]       txt_wdata;
   logic [5:0]       txt_ridx;

   logic [POS_W-1:0] pos_next;
   logic [5:0]       lbl_len;
   logic [POS_W-1:0] lbl_end_pos;
   logic [13:0]      target;
   logic [7:0]       grp_rem;
   logic [2:0]       grp_count;
   logic [3:0][7:0]  grp_chars;
   logic [8:0]       lbl_cost;

   assign pos_next    = pos_ff + POS_W'(1);
   assign lbl_len     = st_rd_ff[5:0];
   assign lbl_end_pos = pos_ff + POS_W'(lbl_len);
   assign target      = {hi_ff, st_rd_ff};
   assign grp_rem     = text_len_ff - {grp_ff, 2'b00};
   assign grp_count   = (grp_rem >= 8'd4) ? 3'd4 : grp_rem[2:0];
   assign lbl_cost    = {3'b000, lbl_len} + 9'd1;
   assign wr_ext      = POS_W'(req.address);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         grp_chars[i] = (3'(i) < grp_count) ? txt_rd_ff[i] : 8'd0;
      end
   end

   always_comb begin
      status.pos_outside    = pos_ff >= PKT_LIM;
      status.byte_zero      = st_rd_ff == 8'd0;
      status.byte_ptr       = st_rd_ff >= PTR_MARK;
      status.byte_reserved  = st_rd_ff > LABEL_MAX;
      status.term_overlong  = ({1'b0, name_len_ff} + 10'd1) > NAME_LIMIT;
      status.label_overlong = ({1'b0, name_len_ff} + 10'd1 + 10'(lbl_len)) > NAME_LIMIT;
      status.label_outside  = lbl_end_pos >= PKT_LIM;
      status.ptr2_outside   = pos_next >= PKT_LIM;
      status.jumps_spent    = jumps_ff >= JUMP_LIM;
      status.target_outside = POS_W'(target) >= PKT_LIM;
      status.label_end      = rem_ff == 6'd1;
      status.group_last     = grp_rem <= 8'd4;
   end

   always_comb begin
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      jumps_in      = jumps_ff;
      jumped_in     = jumped_ff;
      consumed_in   = consumed_ff;
      name_len_in   = name_len_ff;
      text_len_in   = text_len_ff;
      grp_in        = grp_ff;
      hi_in         = hi_ff;
      st_we         = 1'b0;
      st_re         = 1'b0;
      st_raddr      = pos_ff;
      txt_we        = 1'b0;
      txt_wdata     = st_rd_ff;
      txt_re        = 1'b0;
      txt_ridx      = grp_ff + 6'd1;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      case (op)
         OP_WRITE: begin
            st_we = wr_ext < PKT_LIM;
         end
         OP_INIT: begin
            pos_in      = wr_ext;
            jumps_in    = '0;
            jumped_in   = 1'b0;
            consumed_in = '0;
            name_len_in = '0;
            text_len_in = '0;
         end
         OP_READ_POS: begin
            st_re = 1'b1;
         end
         OP_TERM: begin
            name_len_in = name_len_ff + 9'd1;
            if (!jumped_ff) begin
               consumed_in = consumed_ff + 9'd1;
            end
         end
         OP_PTR_HI: begin
            hi_in    = st_rd_ff[5:0];
            st_re    = 1'b1;
            st_raddr = pos_next;
         end
         OP_JUMP: begin
            pos_in    = POS_W'(target);
            jumps_in  = jumps_ff + JW'(1);
            jumped_in = 1'b1;
            if (!jumped_ff) begin
               consumed_in = consumed_ff + 9'd2;
            end
         end
         OP_LABEL: begin
            // separator before every label but the first
            if (text_len_ff != 8'd0) begin
               txt_we      = 1'b1;
               txt_wdata   = DOT_CHAR;
               text_len_in = text_len_ff + 8'd1;
            end
            rem_in      = lbl_len;
            pos_in      = pos_next;
            st_re       = 1'b1;
            st_raddr    = pos_next;
            name_len_in = name_len_ff + lbl_cost;
            if (!jumped_ff) begin
               consumed_in = consumed_ff + lbl_cost;
            end
         end
         OP_CHAR: begin
            txt_we      = 1'b1;
            text_len_in = text_len_ff + 8'd1;
            pos_in      = pos_next;
            rem_in      = rem_ff - 6'd1;
            st_re       = rem_ff != 6'd1;
            st_raddr    = pos_next;
         end
         OP_OUT_START: begin
            grp_in   = '0;
            txt_re   = 1'b1;
            txt_ridx = '0;
         end
         OP_EMIT: begin
            grp_in            = grp_ff + 6'd1;
            txt_re            = 1'b1;
            rsp_strobe_in     = 1'b1;
            rsp_in.char_a     = grp_chars[0];
            rsp_in.char_b     = grp_chars[1];
            rsp_in.char_c     = grp_chars[2];
            rsp_in.char_d     = grp_chars[3];
            rsp_in.char_count = grp_count;
            rsp_in.last       = status.group_last;
            rsp_in.consumed   = status.group_last ? consumed_ff : 9'd0;
         end
         OP_FAIL: begin
            rsp_strobe_in = 1'b1;
            rsp_in.last   = 1'b1;
            rsp_in.error  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store[wr_ext[AW-1:0]] <= req.data_byte;
      end
      if (st_re) begin
         st_rd_ff <= store[st_raddr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (txt_we) begin
         txt_mem[text_len_ff[7:2]][text_len_ff[1:0]] <= txt_wdata;
      end
      if (txt_re) begin
         txt_rd_ff <= txt_mem[txt_ridx];
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rem_ff      <= rem_in;
      jumps_ff    <= jumps_in;
      jumped_ff   <= jumped_in;
      consumed_ff <= consumed_in;
      name_len_ff <= name_len_in;
      text_len_ff <= text_len_in;
      grp_ff      <= grp_in;
      hi_ff       <= hi_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ===== design/dnd_controller.sv =====
// controller of the dns name decompressor: walks labels and pointers,
// then streams the text out; depends on dnd_pkg
module dnd_controller
   import dnd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_kind,
   input  dp_status_type status,
   output dp_op_type     op,
   output logic          busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_DECODE) begin
                  op       = OP_INIT;
                  state_in = ST_FETCH;
               end else begin
                  op = OP_WRITE;
               end
            end
         end
         ST_FETCH: begin
            if (status.pos_outside) begin
               state_in = ST_FAIL;
            end else begin
               op       = OP_READ_POS;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.byte_zero) begin
               if (status.term_overlong) begin
                  state_in = ST_FAIL;
               end else begin
                  op       = OP_TERM;
                  state_in = ST_OUT_RD;
               end
            end else if (status.byte_ptr) begin
               if (status.ptr2_outside || status.jumps_spent) begin
                  state_in = ST_FAIL;
               end else begin
                  op       = OP_PTR_HI;
                  state_in = ST_PTR_LO;
               end
            end else if (status.byte_reserved || status.label_overlong ||
                         status.label_outside) begin
               state_in = ST_FAIL;
            end else begin
               op       = OP_LABEL;
               state_in = ST_LABEL;
            end
         end
         ST_PTR_LO: begin
            if (status.target_outside) begin
               state_in = ST_FAIL;
            end else begin
               op       = OP_JUMP;
               state_in = ST_FETCH;
            end
         end
         ST_LABEL: begin
            op = OP_CHAR;
            if (status.label_end) begin
               state_in = ST_FETCH;
            end
         end
         ST_OUT_RD: begin
            op       = OP_OUT_START;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            op = OP_EMIT;
            if (status.group_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            op       = OP_FAIL;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule

// ===== design/dns_name_decompressor_core.sv =====
// top level of the dns name decompressor: controller plus datapath
// depends on dnd_pkg, dnd_controller and dnd_datapath
//
// usage: a transaction is taken when start is high and busy is low.
// kind write stores data_byte at address; busy stays low, so packet bytes
// can stream in one per clock while no decode holds busy. addresses past the
// store are dropped. kind decode walks the name at address and raises busy.
// decode steps: load the address, then per label read the length byte and
// copy its characters into the text buffer, per pointer read both bytes and
// jump, read the terminator, read the text buffer, then one result per cycle,
// ceil(text / 4) results (one for the root name). each result is registered
// onto rsp_payload and marked by rsp_strobe for a single cycle; the last
// one carries last, consumed and error. an error ends the walk at once and
// gives a single result. the pace comes from the single read port of the
// packet store, one byte per cycle, and the one-word text buffer read.
// reset is synchronous; it idles the controller and clears rsp_strobe, the
// store keeps unknown contents until written. results cannot be held off.
module dns_name_decompressor_core
   import dnd_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   parameter int MAX_JUMPS    = MAX_JUMPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   dp_op_type     op;
   dp_status_type status;

   dnd_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_payload.kind),
      .status   (status),
      .op       (op),
      .busy     (busy)
   );

   dnd_datapath #(
      .PACKET_BYTES (PACKET_BYTES),
      .MAX_JUMPS    (MAX_JUMPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .req        (req_payload),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload)
   );

endmodule

// ===== design/dnd_checker.sv =====
// port-level checks of the dns name decompressor, bound to the top level
// depends on dnd_pkg
module dnd_checker
   import dnd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   // a decode transaction always occupies the block
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.kind == KIND_DECODE |=> busy)
      else $error("decode did not raise busy");

   // a byte write never stalls the next transaction
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_payload.kind == KIND_WRITE |=> !busy)
      else $error("write raised busy");

   // groups before the last one are full
   a_full_group: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |-> rsp_payload.char_count == 3'd4)
      else $error("short group before last");

   // groups of one name leave back to back
   a_group_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |=> rsp_strobe)
      else $error("gap in result stream");

   // a failed decode gives one bare result
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.error |-> rsp_payload.last &&
      rsp_payload.char_count == 3'd0 && rsp_payload.consumed == 9'd0)
      else $error("malformed error result");

endmodule

bind dns_name_decompressor_core dnd_checker u_chk (.*);

// ===== verif/dns_name_decompressor_checker.sv =====
// checker for the dns name decompressor: watches both channels, keeps its own
// copy of the packet store and predicts the character groups of every decode
// depends on dnd_pkg
module dns_name_decompressor_checker
   import dnd_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEF,
   parameter int MAX_JUMPS    = MAX_JUMPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_strobe,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_results
);

   logic [7:0] packet_image [PACKET_BYTES];
   rsp_type    name_groups_due [$];

   // walk the name at origin and queue the character groups it should produce
   task automatic predict_name_groups(input logic [8:0] origin);
      int unsigned pos;
      int unsigned jumps;
      int unsigned wire_len;
      int unsigned used;
      int unsigned ptr_target;
      int unsigned idx;
      int unsigned n;
      int unsigned spelled_len;
      bit          jumped;
      bit          ok;
      bit          done;
      logic [7:0]  lead;
      logic [7:0]  spelled [256];
      rsp_type     res;

      pos         = origin;
      jumps       = 0;
      wire_len    = 0;
      used        = 0;
      spelled_len = 0;
      jumped      = 1'b0;
      ok          = 1'b1;
      done        = 1'b0;
      while (ok && !done) begin
         if (pos >= PACKET_BYTES) begin
            ok = 1'b0;
         end else begin
            lead = packet_image[pos];
            if (lead == 8'd0) begin
               if (wire_len + 1 > NAME_LIMIT) begin
                  ok = 1'b0;
               end else begin
                  wire_len++;
                  if (!jumped) used++;
                  done = 1'b1;
               end
            end else if (lead >= PTR_MARK) begin
               if (pos + 1 >= PACKET_BYTES || jumps >= MAX_JUMPS) begin
                  ok = 1'b0;
               end else begin
                  // removing the 0xc000 marker leaves the low 14 bits
                  ptr_target = {lead[5:0], packet_image[pos + 1]};
                  if (!jumped) begin
                     used  += 2;
                     jumped = 1'b1;
                  end
                  jumps++;
                  if (ptr_target >= PACKET_BYTES) ok = 1'b0;
                  else pos = ptr_target;
               end
            end else if (lead > LABEL_MAX) begin
               ok = 1'b0;
            end else if (wire_len + 1 + lead > NAME_LIMIT || pos + lead >= PACKET_BYTES) begin
               ok = 1'b0;
            end else begin
               if (spelled_len > 0) begin
                  spelled[spelled_len] = DOT_CHAR;
                  spelled_len++;
               end
               for (int k = 1; k <= lead; k++) begin
                  spelled[spelled_len] = packet_image[pos + k];
                  spelled_len++;
               end
               pos      += lead + 1;
               wire_len += lead + 1;
               if (!jumped) used += lead + 1;
            end
         end
      end

      res = '0;
      res.last = 1'b1;
      if (!ok) begin
         res.error = 1'b1;
         name_groups_due.insert(name_groups_due.size(), res);
      end else if (spelled_len == 0) begin
         res.consumed = used[8:0];
         name_groups_due.insert(name_groups_due.size(), res);
      end else begin
         for (idx = 0; idx < spelled_len; idx += 4) begin
            n = (spelled_len - idx > 4) ? 4 : spelled_len - idx;
            res = '0;
            res.char_a = spelled[idx];
            if (n > 1) res.char_b = spelled[idx + 1];
            if (n > 2) res.char_c = spelled[idx + 2];
            if (n > 3) res.char_d = spelled[idx + 3];
            res.char_count = 3'(n);
            res.last       = (idx + 4 >= spelled_len);
            res.consumed   = res.last ? used[8:0] : 9'd0;
            name_groups_due.insert(name_groups_due.size(), res);
         end
      end
   endtask

   task automatic check_field(input string field, input logic [8:0] want, input logic [8:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   task automatic check_group(input rsp_type got);
      rsp_type want;
      if (name_groups_due.size() == 0) begin
         $error("result with no decode outstanding: %h", got);
         fail_count++;
      end else begin
         want = name_groups_due.pop_front();
         check_field("char_a", want.char_a, got.char_a);
         check_field("char_b", want.char_b, got.char_b);
         check_field("char_c", want.char_c, got.char_c);
         check_field("char_d", want.char_d, got.char_d);
         check_field("char_count", want.char_count, got.char_count);
         check_field("last", want.last, got.last);
         check_field("consumed", want.consumed, got.consumed);
         check_field("error", want.error, got.error);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         pending_results <= 0;
      end else begin
         if (rsp_strobe === 1'b1) check_group(rsp_payload);
         if (start && busy === 1'b0) begin
            if (req_payload.kind == KIND_WRITE) begin
               if (int'(req_payload.address) < PACKET_BYTES)
                  packet_image[req_payload.address] = req_payload.data_byte;
            end else begin
               predict_name_groups(req_payload.address);
            end
         end
         pending_results <= name_groups_due.size();
      end
   end

endmodule

// ===== verif/dns_name_decompressor_core_test.sv =====
// testbench top of the dns name decompressor: clock, reset, stimulus, verdict
// depends on dnd_pkg, dns_name_decompressor_core and dns_name_decompressor_checker
module dns_name_decompressor_core_test;
   import dnd_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending_results;

   int      burst_left;
   bit      steady;
   int      sent_items;
   int      name_starts [$];

   dns_name_decompressor_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   dns_name_decompressor_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_payload     (req_payload),
      .rsp_strobe      (rsp_strobe),
      .rsp_payload     (rsp_payload),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("dns_name_decompressor_core_test: FAIL");
      $finish;
   end

   // one transaction, preceded by a random gap when not steady and the current burst is spent
   task automatic send_item(input logic kind, input int addr, input int value);
      req_type item;
      int      gap;
      item.kind      = kind;
      item.address   = addr[8:0];
      item.data_byte = value[7:0];
      if (!steady && burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy !== 1'b0);
      sent_items++;
   endtask

   task automatic put_byte(input int addr, input int value);
      if (addr >= 0 && addr < PACKET_BYTES_DEF) send_item(KIND_WRITE, addr, value);
   endtask

   task automatic decode_at(input int addr);
      send_item(KIND_DECODE, addr, $urandom_range(0, 255));
   endtask

   // length byte plus random characters; bytes past the store are not written
   task automatic write_label(input int at, input int len);
      put_byte(at, len);
      for (int k = 1; k <= len; k++) put_byte(at + k, $urandom_range(0, 255));
   endtask

   task automatic write_pointer(input int at, input int target);
      logic [13:0] dest;
      dest = target[13:0];
      put_byte(at, {2'b11, dest[13:8]});
      put_byte(at + 1, dest[7:0]);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results != 0 || busy !== 1'b0) @(negedge clock);
   endtask

   initial begin
      int mark;
      int scene;
      int pick;
      int base;
      int pos;
      int len;
      int ending;
      int hops;
      int spot;
      int next_spot;
      int first;

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      burst_left  = 0;
      steady      = 1'b1;
      sent_items  = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // every entry gets written first so no decode can read an unset byte
      for (int a = 0; a < PACKET_BYTES_DEF; a++) put_byte(a, $urandom_range(0, 255));

      steady = 1'b0;
      put_byte(400, 0);
      decode_at(400);                     // root name
      write_label(402, 4);
      write_label(407, 1);
      put_byte(409, 0);
      decode_at(402);
      decode_at(407);
      write_label(410, 2);
      write_pointer(413, 402);
      decode_at(410);                     // label then pointer
      decode_at(413);                     // pointer right at the start
      write_pointer(415, 511);
      put_byte(511, 0);
      decode_at(415);                     // highest pointer target
      put_byte(511, PTR_MARK);
      decode_at(511);                     // pointer second byte past the store
      decode_at(415);
      write_pointer(417, 16383);
      decode_at(417);                     // pointer target past the store
      put_byte(419, 64);
      decode_at(419);
      put_byte(419, 191);
      decode_at(419);                     // reserved label types
      write_label(505, 10);
      decode_at(505);                     // label runs off the store
      write_pointer(420, 420);
      decode_at(420);                     // self loop
      for (int k = 0; k < 16; k++) write_pointer(430 + 2 * k, (k == 15) ? 400 : 432 + 2 * k);
      decode_at(430);                     // exactly the jump limit
      write_pointer(428, 430);
      decode_at(428);                     // one jump too many

      for (int k = 0; k < 3; k++) write_label(64 * k, 63);
      write_label(192, 61);
      put_byte(254, 0);
      decode_at(0);                       // longest legal name, 64 groups
      put_byte(192, 62);
      put_byte(254, $urandom_range(1, 255));
      put_byte(255, 0);
      decode_at(0);                       // terminator makes it 256 bytes
      put_byte(192, 63);
      decode_at(0);                       // last label does not fit
      drain();

      name_starts = '{400, 402, 407, 410, 413, 430, 0};
      mark  = sent_items;
      scene = 0;
      while (sent_items - mark < 120) begin
         steady = ($urandom_range(0, 4) == 0);
         pick   = $urandom_range(0, 9);
         if (pick <= 4) begin
            base = $urandom_range(0, 511);
            pos  = base;
            repeat ($urandom_range(0, 4)) begin
               len = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 63) : $urandom_range(1, 7);
               write_label(pos, len);
               pos += len + 1;
            end
            ending = $urandom_range(0, 19);
            if (ending < 12) put_byte(pos, 0);
            else if (ending < 17)
               write_pointer(pos, name_starts[$urandom_range(0, name_starts.size() - 1)]);
            else if (ending < 19) write_pointer(pos, $urandom_range(0, 16383));
            else put_byte(pos, $urandom_range(64, 191));
            decode_at(($urandom_range(0, 4) == 0) ? (base + $urandom_range(1, 3)) % 512 : base);
            name_starts.insert(name_starts.size(), base);
         end else if (pick <= 6) begin
            decode_at(name_starts[$urandom_range(0, name_starts.size() - 1)]);
         end else if (pick == 7) begin
            decode_at($urandom_range(0, 511));
         end else if (pick == 8) begin
            // pointer chain, sometimes longer than the jump limit
            hops  = $urandom_range(1, 18);
            spot  = $urandom_range(0, 510);
            first = spot;
            repeat (hops - 1) begin
               next_spot = $urandom_range(0, 510);
               write_pointer(spot, next_spot);
               spot = next_spot;
            end
            write_pointer(spot, name_starts[$urandom_range(0, name_starts.size() - 1)]);
            decode_at(first);
         end else begin
            repeat ($urandom_range(1, 4)) put_byte($urandom_range(0, 511), $urandom_range(0, 255));
            decode_at(name_starts[$urandom_range(0, name_starts.size() - 1)]);
         end
         scene++;
         if (scene == 15) drain();
      end

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("dns_name_decompressor_core_test: PASS");
      end else begin
         $display("dns_name_decompressor_core_test: FAIL");
      end
      $finish;
   end

endmodule
